// ===== rtl/bencode_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BENCODE_TOKENIZER_ASSERT_SVH
`define BENCODE_TOKENIZER_ASSERT_SVH

// Property checked at each rising edge, off while reset is held.
`define BTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a condition in the next.
`define BTOK_ASSERT_NEXT(label, pre, post, msg) \
  `BTOK_ASSERT(label, (pre) |=> (post), msg)

`endif

// ===== rtl/btok_pkg.sv =====
// Package for the bencode tokenizer: codes, character constants, limits and types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package btok_pkg;

  // Build-time limits
  localparam int MAX_MESSAGE_BYTES = 65536;
  localparam int MAX_DEPTH         = 255;
  localparam int MAX_TOKEN_COUNT   = 4096;

  localparam logic [15:0] MSG_LIMIT =
    16'((MAX_MESSAGE_BYTES < 65535) ? MAX_MESSAGE_BYTES : 65535);
  localparam logic [7:0]  DEPTH_CAP =
    8'((MAX_DEPTH < 255) ? MAX_DEPTH : 255);
  localparam logic [12:0] TOKEN_CAP =
    13'((MAX_TOKEN_COUNT < 8191) ? MAX_TOKEN_COUNT : 8191);

  // Field widths
  localparam int OFF_W  = 16;
  localparam int DEP_W  = 8;
  localparam int CNT_W  = 13;
  localparam int CFG_W  = 13;
  localparam int CFGA_W = 1;

  // Register reset values
  localparam logic [CNT_W-1:0] MAX_TOKENS_RST  = 13'd4096;
  localparam logic [DEP_W-1:0] START_DEPTH_RST = 8'd0;

  typedef enum logic [CFGA_W-1:0] {
    CFG_MAX_TOKENS  = 1'b0,
    CFG_START_DEPTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_TOKEN   = 3'd0,
    ST_DONE    = 3'd1,
    ST_LIMIT   = 3'd2,
    ST_BUF_END = 3'd3,
    ST_ERROR   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    NK_INT  = 3'd0,
    NK_STR  = 3'd1,
    NK_LIST = 3'd2,
    NK_DICT = 3'd3,
    NK_END  = 3'd4
  } kind_t;

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    kind_t            kind;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] length;
    logic [DEP_W-1:0] depth;
    logic [CNT_W-1:0] count;
  } tok_t;

  // Pipeline control between stages
  typedef struct packed {
    logic fire;   // registered byte goes through the parser this cycle
  } pipe_ctl_t;

endpackage

// ===== rtl/btok_in_stage.sv =====
// Input register of the tokenizer: captures one byte transaction per cycle while not stalled.
// Depends on btok_pkg.
`timescale 1ns / 1ps

module btok_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  output logic              in_stall,
  input  logic              hold,
  output btok_pkg::pipe_ctl_t ctl,
  output btok_pkg::in_item_t  item
);
  import btok_pkg::*;

  logic     vld_r;
  in_item_t item_r;

  assign in_stall = vld_r & hold;
  assign ctl.fire = vld_r & ~hold;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{data: in_data_byte, first: in_first_byte, last: in_last_byte};
    end
  end

endmodule

// ===== rtl/btok_core.sv =====
// Parser state and per-byte step logic of the tokenizer, plus its config registers.
// Depends on btok_pkg.
`timescale 1ns / 1ps

module btok_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  btok_pkg::pipe_ctl_t          ctl,
  input  btok_pkg::in_item_t           item,
  input  logic                         cfg_we,
  input  logic [btok_pkg::CFGA_W-1:0]  cfg_addr,
  input  logic [btok_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                         res_valid,
  output btok_pkg::tok_t               res
);
  import btok_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_INT  = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_STOP = 3'd4
  } phase_t;

  logic [CNT_W-1:0] max_tokens_r;
  logic [DEP_W-1:0] start_depth_r;

  phase_t           phase_r, phase_nxt;
  logic [OFF_W-1:0] byte_offset_r, byte_offset_nxt;
  logic [CNT_W-1:0] token_count_r, token_count_nxt;
  logic [DEP_W-1:0] nest_depth_r, nest_depth_nxt;
  logic [OFF_W-1:0] token_start_r, token_start_nxt;
  logic [OFF_W-1:0] string_length_r, string_length_nxt;
  logic [OFF_W-1:0] payload_left_r, payload_left_nxt;

  // state as seen after a first mark has cleared it
  phase_t           ph;
  logic [OFF_W-1:0] off, ts, sl, pl;
  logic [CNT_W-1:0] cnt, cnt1, tok_lim;
  logic [DEP_W-1:0] dep;

  logic [7:0]       b;
  logic [3:0]       digit;
  logic             isdig;
  logic [19:0]      len_x10;
  logic             emit, err;
  kind_t            kind;
  logic [OFF_W-1:0] toff, tlen;
  logic [DEP_W-1:0] tdep;
  status_t          st;

  always_comb begin
    if (max_tokens_r == '0) begin
      tok_lim = CNT_W'(1);
    end else if (max_tokens_r > TOKEN_CAP) begin
      tok_lim = TOKEN_CAP;
    end else begin
      tok_lim = max_tokens_r;
    end
  end

  always_comb begin
    b     = item.data;
    digit = 4'(b - CH_0);
    isdig = (b >= CH_0) && (b <= CH_9);

    ph  = item.first ? PH_IDLE : phase_r;
    off = item.first ? '0 : byte_offset_r;
    cnt = item.first ? '0 : token_count_r;
    dep = item.first ? start_depth_r : nest_depth_r;
    ts  = item.first ? '0 : token_start_r;
    sl  = item.first ? '0 : string_length_r;
    pl  = item.first ? '0 : payload_left_r;

    len_x10 = 20'({sl, 3'b000}) + 20'({sl, 1'b0}) + 20'(digit);
    cnt1    = cnt + CNT_W'(1);

    phase_nxt         = ph;
    byte_offset_nxt   = off;
    token_count_nxt   = cnt;
    nest_depth_nxt    = dep;
    token_start_nxt   = ts;
    string_length_nxt = sl;
    payload_left_nxt  = pl;

    emit = 1'b0;
    err  = 1'b0;
    kind = NK_INT;
    toff = '0;
    tlen = '0;
    tdep = '0;
    st   = ST_TOKEN;

    if (ph != PH_STOP) begin
      if (off >= MSG_LIMIT) begin
        err = 1'b1;
      end else begin
        byte_offset_nxt = off + OFF_W'(1);
        case (ph)
          PH_IDLE: begin
            if (b == CH_I) begin
              token_start_nxt = off + OFF_W'(1);
              phase_nxt       = PH_INT;
            end else if (b == CH_L || b == CH_D) begin
              if (dep >= DEPTH_CAP) begin
                err = 1'b1;
              end else begin
                emit           = 1'b1;
                kind           = (b == CH_L) ? NK_LIST : NK_DICT;
                toff           = off;
                tdep           = dep;
                nest_depth_nxt = dep + DEP_W'(1);
              end
            end else if (b == CH_E) begin
              if (dep == '0) begin
                err = 1'b1;
              end else begin
                nest_depth_nxt = dep - DEP_W'(1);
                emit           = 1'b1;
                kind           = NK_END;
                toff           = off;
                tdep           = dep - DEP_W'(1);
              end
            end else if (isdig) begin
              string_length_nxt = OFF_W'(digit);
              phase_nxt         = PH_LEN;
            end else begin
              err = 1'b1;
            end
          end
          PH_INT: begin
            if (b == CH_E) begin
              emit      = 1'b1;
              kind      = NK_INT;
              toff      = ts;
              tlen      = off - ts;
              phase_nxt = PH_IDLE;
            end else if (b != CH_MINUS && !isdig) begin
              err = 1'b1;
            end
          end
          PH_LEN: begin
            if (isdig) begin
              if (len_x10[19:16] != '0) begin
                err = 1'b1;
              end else begin
                string_length_nxt = len_x10[15:0];
              end
            end else if (b == CH_COLON) begin
              if (sl == '0) begin
                emit      = 1'b1;
                kind      = NK_STR;
                toff      = off + OFF_W'(1);
                phase_nxt = PH_IDLE;
              end else begin
                payload_left_nxt = sl;
                token_start_nxt  = off + OFF_W'(1);
                phase_nxt        = PH_PAY;
              end
            end else begin
              err = 1'b1;
            end
          end
          default: begin
            // string payload: count bytes down and emit the string token on the last one
            if (pl != '0) begin
              payload_left_nxt = pl - OFF_W'(1);
            end
            if (pl <= OFF_W'(1)) begin
              emit      = 1'b1;
              kind      = NK_STR;
              toff      = ts;
              tlen      = sl;
              phase_nxt = PH_IDLE;
            end
          end
        endcase
        // buffer ended mid-token
        if (!emit && !err && item.last) begin
          err = 1'b1;
        end
      end
    end

    if (err) begin
      phase_nxt = PH_STOP;
      st        = ST_ERROR;
      kind      = NK_INT;
      toff      = off;
      tlen      = '0;
      tdep      = dep;
    end else if (emit) begin
      token_count_nxt = cnt1;
      if (nest_depth_nxt == '0) begin
        st = ST_DONE;
      end else if (cnt1 >= tok_lim) begin
        st = ST_LIMIT;
      end else if (item.last) begin
        st = ST_BUF_END;
      end else begin
        st = ST_TOKEN;
      end
      if (st != ST_TOKEN) begin
        phase_nxt = PH_STOP;
      end
    end

    res_valid  = ctl.fire & (emit | err);
    res.status = st;
    res.kind   = kind;
    res.offset = toff;
    res.length = tlen;
    res.depth  = tdep;
    res.count  = err ? cnt : cnt1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r  <= MAX_TOKENS_RST;
      start_depth_r <= START_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MAX_TOKENS:  max_tokens_r  <= cfg_wdata;
        CFG_START_DEPTH: start_depth_r <= cfg_wdata[DEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      byte_offset_r   <= '0;
      token_count_r   <= '0;
      nest_depth_r    <= '0;
      token_start_r   <= '0;
      string_length_r <= '0;
      payload_left_r  <= '0;
    end else if (ctl.fire) begin
      phase_r         <= phase_nxt;
      byte_offset_r   <= byte_offset_nxt;
      token_count_r   <= token_count_nxt;
      nest_depth_r    <= nest_depth_nxt;
      token_start_r   <= token_start_nxt;
      string_length_r <= string_length_nxt;
      payload_left_r  <= payload_left_nxt;
    end
  end

endmodule

// ===== rtl/btok_out_stage.sv =====
// Result register of the tokenizer: holds one token transaction until taken.
// Depends on btok_pkg.
`timescale 1ns / 1ps

module btok_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_valid,
  input  btok_pkg::tok_t              res,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [2:0]                  out_node_kind,
  output logic [btok_pkg::OFF_W-1:0]  out_node_offset,
  output logic [btok_pkg::OFF_W-1:0]  out_node_length,
  output logic [btok_pkg::DEP_W-1:0]  out_node_depth,
  output logic [btok_pkg::CNT_W-1:0]  out_node_count,
  output logic                        hold
);
  import btok_pkg::*;

  logic vld_r;
  tok_t res_r;

  assign hold            = vld_r & out_stall;
  assign out_valid       = vld_r;
  assign out_status      = res_r.status;
  assign out_node_kind   = res_r.kind;
  assign out_node_offset = res_r.offset;
  assign out_node_length = res_r.length;
  assign out_node_depth  = res_r.depth;
  assign out_node_count  = res_r.count;

  // the parser only fires when this register is empty or its result is taken, so a load never overwrites
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_valid) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/bencode_tokenizer.sv =====
// Top level of the streaming bencode tokenizer.
// Depends on btok_pkg, btok_in_stage, btok_core and btok_out_stage.
`timescale 1ns / 1ps

// Takes a bencoded message one byte per transaction, first byte and last byte
// marked, and gives at most one token per byte: status, kind, offset, length,
// depth and running count. Throughput is one byte per clock while the result
// side does not stall; a byte's token passes through the input register, then
// the result register. The parser state loop closes through the core's step
// logic, which sets that rate. A stalled result holds the pipe, and the input
// register then takes a byte only while it is empty. max_tokens (index 0) and
// start_depth (index 1) are written through the cfg port; the user must write
// them only while idle, which the block itself does not enforce.

module bencode_tokenizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_first_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [2:0]                  out_node_kind,
  output logic [btok_pkg::OFF_W-1:0]  out_node_offset,
  output logic [btok_pkg::OFF_W-1:0]  out_node_length,
  output logic [btok_pkg::DEP_W-1:0]  out_node_depth,
  output logic [btok_pkg::CNT_W-1:0]  out_node_count,
  input  logic                        cfg_we,
  input  logic [btok_pkg::CFGA_W-1:0] cfg_addr,
  input  logic [btok_pkg::CFG_W-1:0]  cfg_wdata
);
  import btok_pkg::*;

  pipe_ctl_t ctl;
  in_item_t  item;
  tok_t      res;
  logic      res_valid;
  logic      hold;

  btok_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .in_stall      (in_stall),
    .hold          (hold),
    .ctl           (ctl),
    .item          (item)
  );

  btok_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  btok_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_node_kind   (out_node_kind),
    .out_node_offset (out_node_offset),
    .out_node_length (out_node_length),
    .out_node_depth  (out_node_depth),
    .out_node_count  (out_node_count),
    .hold            (hold)
  );

endmodule

// ===== rtl/btok_checker.sv =====
// Port-level assertions for the bencode tokenizer, bound to the top level.
// Depends on btok_pkg and bencode_tokenizer_assert.svh.
`timescale 1ns / 1ps
`include "bencode_tokenizer_assert.svh"

module btok_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [2:0]                  out_status,
  input logic [2:0]                  out_node_kind,
  input logic [btok_pkg::OFF_W-1:0]  out_node_length,
  input logic [btok_pkg::CNT_W-1:0]  out_node_count
);
  import btok_pkg::*;

  logic tok_err;
  logic tok_ok;
  logic tok_marker;
  logic len_zero;

  assign tok_err    = out_valid && (out_status == ST_ERROR);
  assign tok_ok     = out_valid && (out_status != ST_ERROR);
  assign tok_marker = out_valid && (out_node_kind inside {NK_LIST, NK_DICT, NK_END});
  assign len_zero   = (out_node_length == '0);

  // stalled result transaction stays up
  `BTOK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // error reports carry an integer kind and zero length
  `BTOK_ASSERT(a_err_fields, tok_err |-> out_node_kind == NK_INT && len_zero, "bad error fields")

  // markers carry no length
  `BTOK_ASSERT(a_marker_len, tok_marker |-> len_zero, "marker with length")

  // every real token has been counted
  `BTOK_ASSERT(a_tok_count, tok_ok |-> out_node_count != '0, "token with zero count")

endmodule

bind bencode_tokenizer btok_checker u_btok_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bencode_tokenizer: directed and random messages,
// a scoreboard class that predicts each token and checks the result channel.
// Depends on btok_pkg and the bencode_tokenizer RTL.

module tb;
  import btok_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INT,
    PH_LEN,
    PH_PAY,
    PH_STOP
  } parse_phase_t;

  // Predicts tokens from accepted bytes and checks them in order
  class tok_scoreboard;
    logic [CNT_W-1:0] max_tokens;
    logic [DEP_W-1:0] start_depth;
    parse_phase_t     phase;
    logic [OFF_W-1:0] byte_offset;
    logic [OFF_W-1:0] token_start;
    logic [OFF_W-1:0] string_length;
    logic [OFF_W-1:0] payload_left;
    logic [CNT_W-1:0] token_count;
    logic [DEP_W-1:0] nest_depth;
    tok_t             pending[$];
    int               mismatches;

    function new();
      max_tokens  = MAX_TOKENS_RST;
      start_depth = START_DEPTH_RST;
      mismatches  = 0;
      clear_message();
    endfunction

    function void clear_message();
      phase         = PH_IDLE;
      byte_offset   = '0;
      token_count   = '0;
      nest_depth    = start_depth;
      token_start   = '0;
      string_length = '0;
      payload_left  = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_MAX_TOKENS:  max_tokens = v;
        CFG_START_DEPTH: start_depth = v[DEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void fail_at(logic [OFF_W-1:0] off);
      pending.push_back(tok_t'{ST_ERROR, NK_INT, off, 16'd0, nest_depth, token_count});
      phase = PH_STOP;
    endfunction

    // Returns 0 when the byte falls after a stop and is ignored
    function bit note_byte(logic [7:0] b, logic first, logic last);
      logic [OFF_W-1:0] off;
      logic [19:0]      len_acc;
      logic [CNT_W-1:0] lim;
      bit               is_dig;
      bit               emit;
      kind_t            kind;
      status_t          st;
      logic [OFF_W-1:0] toff;
      logic [OFF_W-1:0] tlen;
      logic [DEP_W-1:0] tdep;
      is_dig = (b >= CH_0) && (b <= CH_9);
      emit   = 1'b0;
      kind   = NK_INT;
      toff   = '0;
      tlen   = '0;
      tdep   = '0;
      if (first) clear_message();
      if (phase == PH_STOP) return 1'b0;
      off = byte_offset;
      if (off >= MSG_LIMIT) begin
        fail_at(off);
        return 1'b1;
      end
      byte_offset = off + 16'd1;
      case (phase)
        PH_IDLE: begin
          if (b == CH_I) begin
            token_start = off + 16'd1;
            phase = PH_INT;
          end else if (b == CH_L || b == CH_D) begin
            if (nest_depth >= DEPTH_CAP) begin
              fail_at(off);
              return 1'b1;
            end
            emit = 1'b1;
            kind = (b == CH_L) ? NK_LIST : NK_DICT;
            toff = off;
            tdep = nest_depth;
            nest_depth = nest_depth + 8'd1;
          end else if (b == CH_E) begin
            if (nest_depth == 0) begin
              fail_at(off);
              return 1'b1;
            end
            nest_depth = nest_depth - 8'd1;
            emit = 1'b1;
            kind = NK_END;
            toff = off;
            tdep = nest_depth;
          end else if (is_dig) begin
            string_length = 16'(b - CH_0);
            phase = PH_LEN;
          end else begin
            fail_at(off);
            return 1'b1;
          end
        end
        PH_INT: begin
          if (b == CH_E) begin
            emit  = 1'b1;
            kind  = NK_INT;
            toff  = token_start;
            tlen  = off - token_start;
            phase = PH_IDLE;
          end else if (b != CH_MINUS && !is_dig) begin
            fail_at(off);
            return 1'b1;
          end
        end
        PH_LEN: begin
          if (is_dig) begin
            len_acc = 20'(string_length) * 20'd10 + 20'(b - CH_0);
            if (len_acc > 20'd65535) begin
              fail_at(off);
              return 1'b1;
            end
            string_length = len_acc[15:0];
          end else if (b == CH_COLON) begin
            if (string_length == 0) begin
              emit  = 1'b1;
              kind  = NK_STR;
              toff  = off + 16'd1;
              phase = PH_IDLE;
            end else begin
              payload_left = string_length;
              token_start  = off + 16'd1;
              phase        = PH_PAY;
            end
          end else begin
            fail_at(off);
            return 1'b1;
          end
        end
        default: begin
          if (payload_left > 0) payload_left = payload_left - 16'd1;
          if (payload_left == 0) begin
            emit  = 1'b1;
            kind  = NK_STR;
            toff  = token_start;
            tlen  = string_length;
            phase = PH_IDLE;
          end
        end
      endcase
      if (!emit) begin
        // buffer ran out mid-token
        if (last) fail_at(off);
        return 1'b1;
      end
      token_count = token_count + 13'd1;
      lim = (max_tokens == 0) ? 13'd1 : max_tokens;
      if (lim > TOKEN_CAP) lim = TOKEN_CAP;
      if (nest_depth == 0)          st = ST_DONE;
      else if (token_count >= lim)  st = ST_LIMIT;
      else if (last)                st = ST_BUF_END;
      else                          st = ST_TOKEN;
      if (st != ST_TOKEN) phase = PH_STOP;
      pending.push_back(tok_t'{st, kind, toff, tlen, tdep, token_count});
      return 1'b1;
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (pending.size() == 0) begin
        $display("%0t: token expected none actual st=%0d kind=%0d off=%0d len=%0d",
                 $time, got.status, got.kind, got.offset, got.length);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      cmp_field("status", 16'(want.status), 16'(got.status));
      cmp_field("node_kind", 16'(want.kind), 16'(got.kind));
      cmp_field("node_offset", want.offset, got.offset);
      cmp_field("node_length", want.length, got.length);
      cmp_field("node_depth", 16'(want.depth), 16'(got.depth));
      cmp_field("node_count", 16'(want.count), 16'(got.count));
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 300;
  localparam int SEG_BYTES      = 75;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = 8'd0;
  logic               in_first_byte = 1'b0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic [2:0]         out_node_kind;
  logic [OFF_W-1:0]   out_node_offset;
  logic [OFF_W-1:0]   out_node_length;
  logic [DEP_W-1:0]   out_node_depth;
  logic [CNT_W-1:0]   out_node_count;
  logic               cfg_we = 1'b0;
  logic [CFGA_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  tok_scoreboard tokens = new;
  tok_t          observed;
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  bit            hold_tog = 1'b0;
  bit            hold_seen = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  int            live_bytes = 0;
  logic [7:0]    msg_q[$];

  bencode_tokenizer dut (.*);

  assign observed = {out_status, out_node_kind, out_node_offset, out_node_length,
                     out_node_depth, out_node_count};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure; a toggle of hold_tog starts a long hold-off
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tokens.check_token(observed);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_text(string s);
    foreach (s[i]) msg_q.push_back(s[i]);
  endfunction

  function automatic void gen_string();
    int len;
    len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(5);
    if ($urandom_range(9) == 0) msg_q.push_back(CH_0);
    push_text($sformatf("%0d", len));
    msg_q.push_back(CH_COLON);
    repeat (len) msg_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    case ((lvl == 0) ? $urandom_range(1) : $urandom_range(3))
      0: begin
        msg_q.push_back(CH_I);
        if ($urandom_range(3) == 0) msg_q.push_back(CH_MINUS);
        n = $urandom_range(4);
        repeat (n) msg_q.push_back(8'(CH_0 + $urandom_range(9)));
        msg_q.push_back(CH_E);
      end
      1: gen_string();
      2: begin
        msg_q.push_back(CH_L);
        n = $urandom_range(3);
        repeat (n) gen_value(lvl - 1);
        msg_q.push_back(CH_E);
      end
      default: begin
        msg_q.push_back(CH_D);
        n = $urandom_range(3);
        repeat (n) begin
          gen_string();
          gen_value(lvl - 1);
        end
        msg_q.push_back(CH_E);
      end
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic first, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= first;
    in_last_byte  <= last;
    do @(posedge clk); while (in_stall);
    if (tokens.note_byte(b, first, last)) live_bytes++;
  endtask

  task automatic send_msg(bit first_mark, bit last_mark);
    int n;
    n = msg_q.size();
    for (int i = 0; i < n; i++)
      send_byte(msg_q[i], first_mark && i == 0, last_mark && i == n - 1);
    msg_q.delete();
  endtask

  // Stop offering and wait for every predicted token, plus the pipe latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(logic [CFG_W-1:0] tok_max, logic [DEP_W-1:0] depth0);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MAX_TOKENS;
    cfg_wdata <= tok_max;
    @(posedge clk);
    tokens.write_reg(CFG_MAX_TOKENS, tok_max);
    cfg_addr  <= CFG_START_DEPTH;
    cfg_wdata <= CFG_W'(depth0);
    @(posedge clk);
    tokens.write_reg(CFG_START_DEPTH, CFG_W'(depth0));
    cfg_we <= 1'b0;
  endtask

  task automatic random_message();
    int  cut;
    bit  first_mark;
    bit  last_mark;
    gen_value($urandom_range(3));
    // trailing value: ignored after a done, parsed when start depth is non-zero
    if ($urandom_range(3) == 0) gen_value(1);
    first_mark = ($urandom_range(19) != 0);
    last_mark  = ($urandom_range(9) != 0);
    case ($urandom_range(9))
      0: msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
      1: begin
        cut = $urandom_range(1, msg_q.size());
        while (msg_q.size() > cut) void'(msg_q.pop_back());
      end
      2: repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(255)));
      3: begin
        msg_q.delete();
        repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    send_msg(first_mark, last_mark);
  endtask

  initial begin
    logic [CFG_W-1:0] tok_max;
    logic [DEP_W-1:0] depth0;
    int               r;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 12;
    rx_idle_pct = 61;
    // bytes ahead of any first mark run from the reset state
    push_text("i-9e");
    send_msg(1'b0, 1'b1);
    push_text("ie");
    send_msg(1'b1, 1'b1);
    push_text("0:");
    send_msg(1'b1, 1'b1);
    push_text("e");
    send_msg(1'b1, 1'b1);
    msg_q.push_back(8'hFF);
    send_msg(1'b1, 1'b1);
    msg_q.push_back(CH_I);
    msg_q.push_back(8'h00);
    send_msg(1'b1, 1'b1);
    push_text("li9");
    send_msg(1'b1, 1'b1);
    push_text("70000:");
    send_msg(1'b1, 1'b1);
    settle();
    set_limits(13'd1, 8'd255);
    push_text("l");
    send_msg(1'b1, 1'b0);
    settle();
    set_limits(13'd0, 8'd1);
    push_text("ie");
    send_msg(1'b1, 1'b0);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 61 : 0;
      rx_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 12 : 0;
      for (int seg = 0; seg < 2; seg++) begin
        settle();
        case ($urandom_range(5))
          0: tok_max = 13'd0;
          1: tok_max = 13'd1;
          2: tok_max = 13'd8191;
          3: tok_max = 13'($urandom_range(2, 8));
          4: tok_max = MAX_TOKENS_RST;
          default: tok_max = 13'($urandom_range(1, 8191));
        endcase
        r = $urandom_range(15);
        if (r == 0)      depth0 = 8'd255;
        else if (r == 1) depth0 = 8'd254;
        else if (r < 4)  depth0 = 8'($urandom_range(1, 3));
        else             depth0 = 8'd0;
        set_limits(tok_max, depth0);
        // result side holds off while the sender keeps offering
        if (mode == 2 && seg == 0) hold_tog <= ~hold_tog;
        live_bytes = 0;
        while (live_bytes < SEG_BYTES) random_message();
      end
    end

    settle();
    if (tokens.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/btok_pkg.sv
rtl/btok_in_stage.sv
rtl/btok_core.sv
rtl/btok_out_stage.sv
rtl/bencode_tokenizer.sv
rtl/btok_checker.sv
tb/tb.sv
